>>> hw/rtl/per_class_bm25_scorer_defines.svh
// assertion macros shared by the checker of the per-class bm25 scorer
// no dependencies; every macro is clocked on aclk and idle during reset
`ifndef PER_CLASS_BM25_SCORER_DEFINES_SVH
`define PER_CLASS_BM25_SCORER_DEFINES_SVH

// condition holds in the same cycle
`define BM25_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define BM25_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bm25_pkg.sv
// shared types, constants and elaboration-time log table functions
// for the per-class bm25 scorer; no dependencies
package bm25_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRAIN_RD,
        ST_TRAIN_WR,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_SC_RD,
        ST_SC_NORM,
        ST_SC_NDIV,
        ST_SC_DEN,
        ST_SC_TDIV,
        ST_SC_ACC,
        ST_EMIT
    } bm25_state_t;

    typedef enum logic [1:0] {
        MODE_TRAIN = 2'd0,
        MODE_SCORE = 2'd1,
        MODE_EMIT  = 2'd2,
        MODE_NOP   = 2'd3
    } bm25_mode_t;

    typedef enum logic [1:0] {
        REG_SAT_K   = 2'd0,
        REG_LEN_B   = 2'd1,
        REG_IDF_FLR = 2'd2,
        REG_NONE    = 2'd3
    } bm25_reg_t;

    localparam int DIV_NW = 65;   // dividend width
    localparam int DIV_DW = 45;   // divisor width
    localparam int MAX_EMIT = 8;

    localparam logic [12:0] ONE_Q12   = 13'd4096;
    localparam logic [39:0] NORM_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    localparam logic [15:0] K_RESET     = 16'd6144;
    localparam logic [12:0] B_RESET     = 13'd3072;
    localparam logic [31:0] FLOOR_RESET = 32'd66;

    // log2 in q.24 by repeated squaring of a q.30 mantissa
    function automatic logic [63:0] log2_q24(input logic [63:0] m);
        logic [63:0] e;
        logic [63:0] y;
        logic [63:0] r;
        e = 64'd0;
        for (int j = 0; j < 62; j++) begin
            if ((m >> (e + 64'd1)) != 64'd0) begin
                e = e + 64'd1;
            end
        end
        y = (m << 30) >> e;
        r = e << 24;
        for (int i = 23; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    // ln((2n - 2c + 1) / (2c + 1)) in signed q16.16
    function automatic logic signed [31:0] idf_entry(input int n, input int c);
        logic [63:0] la;
        logic [63:0] ld;
        logic [63:0] mag;
        logic [63:0] v;
        la = log2_q24(64'(2 * (n - c) + 1));
        ld = log2_q24(64'(2 * c + 1));
        mag = (la < ld) ? (ld - la) : (la - ld);
        v = (mag * LN2_Q32 + (64'd1 << 39)) >> 40;
        return (la < ld) ? -$signed(v[31:0]) : $signed(v[31:0]);
    endfunction

endpackage

>>> hw/rtl/bm25_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on bm25_pkg for the operand widths
module bm25_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [bm25_pkg::DIV_NW-1:0] dividend,
    input  logic [bm25_pkg::DIV_DW-1:0] divisor,
    output logic                       done,
    output logic [bm25_pkg::DIV_NW-1:0] quotient
);
    import bm25_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> hw/rtl/bm25_mem.sv
// term-count memory: one write port, one registered read port
// no package dependencies
module bm25_mem #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/per_class_bm25_scorer.sv
// per-class bm25 scorer top level: sequencer, counters, totals, accumulators
// depends on bm25_pkg, bm25_mem and bm25_div
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata class/token/count
//  m_      | out | m_tvalid/m_tready  | m_tdata class/score, m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// after reset the term memory is swept to zero, NUM_CLASSES * 2^ceil(log2(min(
// VOCAB_SIZE,4096))) words, with s_tready low; one request is worked on at a time.
// train reads, then writes the count. emit gives one class result per cycle
// unless the output stalls. score runs the shared 65-step divider for the norm
// (not when the class total is zero) and the term of each class holding the token.
module per_class_bm25_scorer #(
    parameter int NUM_CLASSES = 8,
    parameter int VOCAB_SIZE  = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [2:0] class_id, [14:3] token, [30:15] token_count
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] class_index, [34:3] score
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bm25_pkg::*;

    localparam int CW     = $clog2(NUM_CLASSES);
    localparam int TW_ALL = $clog2(VOCAB_SIZE);
    localparam int TW     = (TW_ALL > 12) ? 12 : TW_ALL;
    localparam int AW     = CW + TW;
    localparam int DEPTH  = NUM_CLASSES << TW;
    localparam int HW     = $clog2(NUM_CLASSES + 1);
    localparam int EMIT_N = (NUM_CLASSES < MAX_EMIT) ? NUM_CLASSES : MAX_EMIT;

    bm25_state_t state_reg, state_next;

    logic [2:0]  cls_reg, cls_next;
    logic [11:0] tok_reg, tok_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [CW-1:0] cidx_reg, cidx_next;
    logic [HW-1:0] held_reg, held_next;
    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [31:0] f_reg, f_next;
    logic [39:0] norm_reg, norm_next;
    logic [37:0] p_reg, p_next;
    logic [2:0]  ecnt_reg, ecnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        ov_reg, ov_next;
    logic [2:0]  ocls_reg, ocls_next;
    logic [31:0] oscore_reg, oscore_next;
    logic        olast_reg, olast_next;
    logic [15:0] k_reg;
    logic [12:0] b_reg;
    logic [31:0] floor_reg;
    logic [39:0] overall_reg, overall_next;
    logic [31:0] tot_reg [NUM_CLASSES];
    logic [31:0] tot_next [NUM_CLASSES];
    logic [31:0] acc_reg [NUM_CLASSES];
    logic [31:0] acc_next [NUM_CLASSES];

    logic signed [31:0] idf_rom [NUM_CLASSES + 1];

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_q;
    logic [DIV_DW-1:0] div_den;

    for (genvar g = 0; g <= NUM_CLASSES; g++) begin : g_idf
        assign idf_rom[g] = idf_entry(NUM_CLASSES, g);
    end

    bm25_mem #(.AW(AW), .DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bm25_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        logic [12:0]        b_eff;
        logic               tok_ok;
        logic               cls_ok;
        logic [32:0]        sum33;
        logic [40:0]        sum41;
        logic [HW-1:0]      held_inc;
        logic signed [31:0] idf;
        logic [31:0]        tot;
        logic [65:0]        norm_sum;
        logic [55:0]        kn;
        logic [44:0]        den;
        logic [48:0]        num;
        logic [53:0]        prod;
        logic signed [39:0] s;
        logic               last_cls;
        logic [CW-1:0]      ecls;

        b_eff    = (b_reg > ONE_Q12) ? ONE_Q12 : b_reg;
        tok_ok   = {20'd0, s_tdata[14:3]} < 32'(VOCAB_SIZE);
        cls_ok   = {3'd0, s_tdata[2:0]} < 6'(NUM_CLASSES);
        last_cls = cidx_reg == CW'(NUM_CLASSES - 1);
        tot      = tot_reg[cidx_reg];
        held_inc = held_reg + HW'(mem_rdata != 32'd0);
        idf      = idf_rom[held_inc];
        if (idf < $signed(floor_reg)) begin
            idf = $signed(floor_reg);
        end
        sum33    = {1'b0, mem_rdata} + {17'd0, cnt_reg};
        sum41    = '0;
        norm_sum = {53'd0, ONE_Q12 - b_eff} + {1'b0, div_q};
        kn       = 56'(k_reg) * 56'(norm_reg);
        den      = 45'({f_reg, 12'd0}) + 45'(kn[55:12]);
        num      = 49'(f_reg) * 49'({1'b0, k_reg} + 17'd4096);
        prod     = 54'(mag_reg) * 54'(div_q[21:0]);
        s        = 40'($signed(acc_reg[cidx_reg]))
                   + (neg_reg ? -$signed({2'b00, p_reg}) : $signed({2'b00, p_reg}));
        ecls     = CW'(ecnt_reg + 3'd1);

        state_next  = state_reg;
        cls_next    = cls_reg;
        tok_next    = tok_reg;
        cnt_next    = cnt_reg;
        cidx_next   = cidx_reg;
        held_next   = held_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        f_next      = f_reg;
        norm_next   = norm_reg;
        p_next      = p_reg;
        ecnt_next   = ecnt_reg;
        clr_next    = clr_reg;
        ov_next     = ov_reg;
        ocls_next   = ocls_reg;
        oscore_next = oscore_reg;
        olast_next  = olast_reg;
        overall_next = overall_reg;
        tot_next    = tot_reg;
        acc_next    = acc_reg;
        mem_we      = 1'b0;
        mem_waddr   = {CW'(cls_reg), tok_reg[TW-1:0]};
        mem_wdata   = '0;
        mem_raddr   = {cidx_reg, tok_reg[TW-1:0]};
        div_start   = 1'b0;
        div_num     = DIV_NW'(53'(b_eff) * 53'(overall_reg));
        div_den     = 45'(37'(tot) * 37'(NUM_CLASSES));
        s_tready    = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cls_next  = s_tdata[2:0];
                    tok_next  = s_tdata[14:3];
                    cnt_next  = s_tdata[30:15];
                    cidx_next = '0;
                    held_next = '0;
                    case (bm25_mode_t'(s_tuser))
                        MODE_TRAIN: begin
                            if (tok_ok && cls_ok) begin
                                state_next = ST_TRAIN_RD;
                            end
                        end
                        MODE_SCORE: begin
                            if (tok_ok) begin
                                state_next = ST_CNT_RD;
                            end
                        end
                        MODE_EMIT: begin
                            ecnt_next   = 3'd0;
                            ov_next     = 1'b1;
                            ocls_next   = 3'd0;
                            oscore_next = acc_reg[0];
                            olast_next  = EMIT_N == 1;
                            state_next  = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TRAIN_RD: begin
                mem_raddr  = {CW'(cls_reg), tok_reg[TW-1:0]};
                state_next = ST_TRAIN_WR;
            end
            ST_TRAIN_WR: begin
                mem_we    = 1'b1;
                mem_wdata = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                sum33     = {1'b0, tot_reg[CW'(cls_reg)]} + {17'd0, cnt_reg};
                tot_next[CW'(cls_reg)] = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                sum41     = {1'b0, overall_reg} + {25'd0, cnt_reg};
                overall_next = (sum41 > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum41[39:0];
                state_next = ST_IDLE;
            end
            ST_CNT_RD: begin
                state_next = ST_CNT_ACC;
            end
            ST_CNT_ACC: begin
                held_next = held_inc;
                if (last_cls) begin
                    neg_next   = idf[31];
                    mag_next   = idf[31] ? 32'(-idf) : idf;
                    cidx_next  = '0;
                    state_next = ST_SC_RD;
                end else begin
                    cidx_next  = cidx_reg + CW'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_SC_RD: begin
                state_next = ST_SC_NORM;
            end
            ST_SC_NORM: begin
                f_next = mem_rdata;
                if (mem_rdata == 32'd0) begin
                    // class does not hold the token, no change
                    if (last_cls) begin
                        state_next = ST_IDLE;
                    end else begin
                        cidx_next  = cidx_reg + CW'(1);
                        state_next = ST_SC_RD;
                    end
                end else if (tot == 32'd0) begin
                    norm_next  = NORM_MAX;
                    state_next = ST_SC_DEN;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_SC_NDIV;
                end
            end
            ST_SC_NDIV: begin
                if (div_done) begin
                    norm_next  = (norm_sum > {26'd0, NORM_MAX}) ? NORM_MAX : norm_sum[39:0];
                    state_next = ST_SC_DEN;
                end
            end
            ST_SC_DEN: begin
                div_start  = 1'b1;
                div_num    = {num, 16'd0};
                div_den    = den;
                state_next = ST_SC_TDIV;
            end
            ST_SC_TDIV: begin
                if (div_done) begin
                    p_next     = prod[53:16];
                    state_next = ST_SC_ACC;
                end
            end
            ST_SC_ACC: begin
                if (s > 40'sd2147483647) begin
                    acc_next[cidx_reg] = 32'h7FFF_FFFF;
                end else if (s < -40'sd2147483648) begin
                    acc_next[cidx_reg] = 32'h8000_0000;
                end else begin
                    acc_next[cidx_reg] = s[31:0];
                end
                if (last_cls) begin
                    state_next = ST_IDLE;
                end else begin
                    cidx_next  = cidx_reg + CW'(1);
                    state_next = ST_SC_RD;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (olast_reg) begin
                        ov_next    = 1'b0;
                        state_next = ST_IDLE;
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                            acc_next[i] = '0;
                        end
                    end else begin
                        ecnt_next   = ecnt_reg + 3'd1;
                        ocls_next   = ecnt_reg + 3'd1;
                        oscore_next = acc_reg[ecls];
                        olast_next  = ecnt_reg == 3'(EMIT_N - 2);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            ov_reg      <= 1'b0;
            overall_reg <= 40'd1;
            k_reg       <= K_RESET;
            b_reg       <= B_RESET;
            floor_reg   <= FLOOR_RESET;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                tot_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ov_reg      <= ov_next;
            overall_reg <= overall_next;
            tot_reg     <= tot_next;
            acc_reg     <= acc_next;
            if (cfg_valid) begin
                case (bm25_reg_t'(cfg_index))
                    REG_SAT_K:   k_reg     <= cfg_data[15:0];
                    REG_LEN_B:   b_reg     <= cfg_data[12:0];
                    REG_IDF_FLR: floor_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        cls_reg    <= cls_next;
        tok_reg    <= tok_next;
        cnt_reg    <= cnt_next;
        cidx_reg   <= cidx_next;
        held_reg   <= held_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        f_reg      <= f_next;
        norm_reg   <= norm_next;
        p_reg      <= p_next;
        ecnt_reg   <= ecnt_next;
        ocls_reg   <= ocls_next;
        oscore_reg <= oscore_next;
        olast_reg  <= olast_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {5'd0, oscore_reg, ocls_reg};
    assign m_tlast   = olast_reg;
endmodule

>>> hw/rtl/bm25_checker.sv
// port-level checker for the per-class bm25 scorer, bound to the top level
// depends on per_class_bm25_scorer_defines.svh
`include "per_class_bm25_scorer_defines.svh"

module bm25_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    `BM25_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `BM25_ASSERT_NOW(a_no_take_busy, m_tvalid, !s_tready, "request taken while results pending")
    `BM25_ASSERT_NEXT(a_class_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1), "class results out of order")
    `BM25_ASSERT_NEXT(a_end_emit, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after last")
endmodule

bind per_class_bm25_scorer bm25_checker u_bm25_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/tb_per_class_bm25_scorer.sv
// self-checking bench for the per-class bm25 scorer: trains counts, scores tokens,
// emits class scores and compares them with a bit-exact predictor of the block
// depends on bm25_pkg and per_class_bm25_scorer
module tb_per_class_bm25_scorer;
    timeunit 1ns;
    timeprecision 1ps;
    import bm25_pkg::*;

    localparam int NCLS = 8;
    localparam int NTOK = 4096;
    localparam int IDLE_LIMIT = 100000;
    localparam int SETTLE = 1500;

    typedef struct {
        logic [2:0]  cls;
        logic [31:0] score;
        logic        last;
    } class_score_t;

    class bm25_score_model;
        bit [31:0] counts [NCLS][NTOK];
        bit [31:0] cls_total [NCLS];
        longint unsigned doc_total;
        longint acc [NCLS];
        longint idf [NCLS + 1];
        longint unsigned k_q12;
        longint unsigned b_q12;
        longint floor_q16;
        class_score_t expected_scores [$];
        int errors;
        int checked;

        function new();
            for (int c = 0; c < NCLS; c++) begin
                cls_total[c] = 0;
                acc[c] = 0;
                for (int t = 0; t < NTOK; t++) counts[c][t] = 0;
            end
            doc_total = 1;
            for (int c = 0; c <= NCLS; c++) idf[c] = ln_ratio(2 * (NCLS - c) + 1, 2 * c + 1);
            k_q12 = 6144;
            b_q12 = 3072;
            floor_q16 = 66;
            errors = 0;
            checked = 0;
        endfunction

        // log2 in q.24 via repeated squaring of a q.30 mantissa
        function longint unsigned lg2(longint unsigned m);
            longint unsigned e, y, r;
            e = 0;
            while (e < 62 && (m >> (e + 1)) != 0) e++;
            y = (m << 30) >> e;
            r = e << 24;
            for (int i = 23; i >= 0; i--) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    r = r | (64'd1 << i);
                end
            end
            return r;
        endfunction

        function longint ln_ratio(longint unsigned num, longint unsigned den);
            longint unsigned la, ld, mag, v;
            la = lg2(num);
            ld = lg2(den);
            mag = (la < ld) ? ld - la : la - ld;
            v = (mag * 64'd2977044472 + (64'd1 << 39)) >> 40;
            return (la < ld) ? -longint'(v) : longint'(v);
        endfunction

        function longint unsigned tf_q16(longint unsigned f, longint unsigned tot);
            longint unsigned b, norm, num, den, q, r;
            b = (b_q12 > 4096) ? 4096 : b_q12;
            if (f == 0) return 0;
            if (tot == 0) begin
                norm = (64'd1 << 40) - 1;
            end else begin
                norm = (4096 - b) + (b * doc_total) / (NCLS * tot);
                if (norm > (64'd1 << 40) - 1) norm = (64'd1 << 40) - 1;
            end
            num = f * (k_q12 + 4096);
            den = f * 4096 + ((k_q12 * norm) >> 12);
            q = num / den;
            r = num % den;
            return (q << 16) + (r << 16) / den;
        endfunction

        function void write_reg(bm25_reg_t idx, logic [31:0] val);
            case (idx)
                REG_SAT_K: k_q12 = val[15:0];
                REG_LEN_B: b_q12 = val[12:0];
                REG_IDF_FLR: floor_q16 = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function void note_request(bm25_mode_t mode, logic [2:0] cls, logic [11:0] tok,
                                   logic [15:0] cnt);
            int held;
            longint w, s;
            longint unsigned mag, p, sum;
            class_score_t e;
            case (mode)
                MODE_TRAIN: begin
                    sum = longint'(counts[cls][tok]) + cnt;
                    counts[cls][tok] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    sum = longint'(cls_total[cls]) + cnt;
                    cls_total[cls] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    doc_total = doc_total + cnt;
                    if (doc_total > (64'd1 << 40) - 1) doc_total = (64'd1 << 40) - 1;
                end
                MODE_SCORE: begin
                    held = 0;
                    for (int c = 0; c < NCLS; c++) if (counts[c][tok] != 0) held++;
                    w = idf[held];
                    if (w < floor_q16) w = floor_q16;
                    mag = (w < 0) ? -w : w;
                    for (int c = 0; c < NCLS; c++) begin
                        p = (mag * tf_q16(counts[c][tok], cls_total[c])) >> 16;
                        s = acc[c] + ((w < 0) ? -longint'(p) : longint'(p));
                        if (s > 64'sd2147483647) s = 64'sd2147483647;
                        if (s < -64'sd2147483648) s = -64'sd2147483648;
                        acc[c] = s;
                    end
                end
                MODE_EMIT: begin
                    for (int c = 0; c < NCLS; c++) begin
                        e.cls = c;
                        e.score = acc[c][31:0];
                        e.last = (c == NCLS - 1);
                        expected_scores.push_back(e);
                        acc[c] = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_score(logic [2:0] cls, logic [31:0] score, logic last);
            class_score_t e;
            checked++;
            if (expected_scores.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected score: class %0d score %h last %0d", cls, score, last);
                return;
            end
            e = expected_scores.pop_front();
            if (e.cls !== cls || e.score !== score || e.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("score mismatch: expected class %0d score %h last %0d, got %0d %h %0d",
                             e.cls, e.score, e.last, cls, score, last);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    bm25_score_model sb;
    logic [11:0] hot_tokens [8];
    bit quiet;
    bit long_hold;
    int idle_cycles;
    int requests;

    per_class_bm25_scorer #(.NUM_CLASSES(NCLS), .VOCAB_SIZE(NTOK)) dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic send_request(bm25_mode_t mode, logic [2:0] cls, logic [11:0] tok,
                                logic [15:0] cnt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {1'b0, cnt, tok, cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(mode, cls, tok, cnt);
        if (mode != MODE_NOP) requests++;
    endtask

    task automatic write_reg(bm25_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, let every expected score arrive, then let a long score finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_requests(int n);
        int r;
        int done;
        logic [11:0] tok;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            tok = ($urandom_range(0, 9) < 7) ? hot_tokens[$urandom_range(0, 7)]
                                             : 12'($urandom);
            if (r < 45) begin
                send_request(MODE_TRAIN, 3'($urandom), tok,
                             ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 40)));
                done++;
            end else if (r < 80) begin
                send_request(MODE_SCORE, 3'($urandom), tok, 16'($urandom));
                done++;
            end else if (r < 92) begin
                send_request(MODE_EMIT, 3'($urandom), tok, 16'($urandom));
                done++;
            end else begin
                send_request(MODE_NOP, 3'($urandom), 12'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 60) == 0) quiet = !quiet;
        end
        send_request(MODE_EMIT, 3'd0, 12'd0, 16'd0);
    endtask

    // result side: random backpressure plus one long hold on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_score(m_tdata[2:0], m_tdata[34:3], m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sb = new();
        idle_cycles = 0;
        requests = 0;
        quiet = 0;
        long_hold = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hot_tokens[0] = 12'd0;
        hot_tokens[1] = 12'd4095;
        for (int i = 2; i < 8; i++) hot_tokens[i] = 12'($urandom);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, tokens held by none / some / all classes
        send_request(MODE_EMIT, 3'd0, 12'd0, 16'd0);
        send_request(MODE_SCORE, 3'd5, 12'd1234, 16'd0);
        send_request(MODE_TRAIN, 3'd0, 12'd0, 16'd65535);
        send_request(MODE_TRAIN, 3'd7, 12'd4095, 16'd1);
        send_request(MODE_TRAIN, 3'd3, 12'd4095, 16'd0);
        for (int c = 0; c < NCLS; c++) send_request(MODE_TRAIN, 3'(c), 12'd2730, 16'(c + 1));
        send_request(MODE_SCORE, 3'd0, 12'd0, 16'd0);
        send_request(MODE_SCORE, 3'd0, 12'd4095, 16'd0);
        send_request(MODE_SCORE, 3'd0, 12'd2730, 16'd0);
        send_request(MODE_NOP, 3'd7, 12'd4095, 16'hFFFF);
        send_request(MODE_SCORE, 3'd2, 12'd7, 16'd0);
        send_request(MODE_EMIT, 3'd7, 12'd4095, 16'hFFFF);
        random_requests(60);
        settle();

        write_reg(REG_SAT_K, 32'd65535);
        write_reg(REG_LEN_B, 32'd8191);
        write_reg(REG_IDF_FLR, 32'h8000_0000);
        random_requests(60);

        // hold off results while requests keep coming
        settle();
        send_request(MODE_SCORE, 3'd0, 12'd2730, 16'd0);
        long_hold = 1;
        send_request(MODE_EMIT, 3'd0, 12'd0, 16'd0);
        for (int i = 0; i < 6; i++) send_request(MODE_TRAIN, 3'(i), hot_tokens[i], 16'd3);
        settle();

        write_reg(REG_SAT_K, 32'd0);
        write_reg(REG_LEN_B, 32'd0);
        write_reg(REG_IDF_FLR, 32'h7FFF_FFFF);
        random_requests(60);
        settle();

        write_reg(REG_SAT_K, 32'd1);
        write_reg(REG_LEN_B, 32'd4096);
        write_reg(REG_IDF_FLR, 32'hFFFD_0000);
        random_requests(60);
        settle();

        write_reg(REG_SAT_K, 32'($urandom_range(0, 65535)));
        write_reg(REG_LEN_B, 32'($urandom_range(0, 4096)));
        write_reg(REG_IDF_FLR, 32'd0);
        random_requests(60);
        settle();

        $display("covered %0d requests and %0d class scores over five register settings",
                 requests, sb.checked);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d score mismatches", sb.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
